### src/assert_macros.svh
// Assertion helpers for any file that checks its own logic.
// Each check is sampled on the rising edge of clk and is switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### src/mexp_pkg.sv
package mexp_pkg;

    // Field widths
    localparam int MOD_W = 31;
    localparam int EXP_W = 63;
    localparam int DIV_W = 63;
    localparam int CNT_W = 6;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef struct packed {
        logic [EXP_W-1:0] base_value;
        logic [EXP_W-1:0] exponent;
    } mexp_in_t;

    typedef struct packed {
        logic [MOD_W-1:0] power_result;
    } mexp_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL
    } mexp_state_t;

    // What the reduction unit is working on
    typedef enum logic [1:0] {
        OP_BASE,
        OP_ACC,
        OP_SQR
    } mexp_op_t;

endpackage

### src/mexp_in_if.sv
interface mexp_in_if import mexp_pkg::*; ();
    logic     valid;
    logic     ready;
    mexp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/mexp_out_if.sv
interface mexp_out_if import mexp_pkg::*; ();
    logic      valid;
    logic      ready;
    mexp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/modular_exponentiation.sv
// Modular exponentiation: each operand transfer carries a base and an exponent, and one
// result transfer returns base^exponent mod modulus, where modulus is the register written
// through cfg_we/cfg_wdata (reset value 1000000007; a written zero acts as 1). An exponent
// of zero gives 1. Exponent bits at or above EXP_BITS are ignored. The block works on one
// item at a time with a single 31x31 multiplier and a bit-serial restoring remainder unit
// that retires one dividend bit per cycle. The base is reduced first, and each multiply or
// squaring is followed by its own reduction. With k the index of the top set exponent bit
// plus one and p the number of set bits, an item needs p multiplies and k - 1 squarings.
// A finished item holds until the previous result has been taken by the sink.
// The finished result sits in an output register, so the next operand may be taken while
// it waits for the sink.
`include "assert_macros.svh"

module modular_exponentiation import mexp_pkg::*; #(
    parameter int EXP_BITS = 63
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MOD_W-1:0] cfg_wdata,
    mexp_in_if.sink          operand,
    mexp_out_if.source       result
);

    localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - EXP_BITS);

    mexp_state_t      state_reg, state_next;
    mexp_op_t         op_reg, op_next;
    logic [MOD_W-1:0] modulus_reg;
    logic [MOD_W-1:0] m_reg, m_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] b_reg, b_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [MOD_W-1:0] out_data_reg, out_data_next;

    logic [MOD_W:0]     trial;
    logic [MOD_W:0]     trial_diff;
    logic [MOD_W-1:0]   red_rem;
    logic [MOD_W-1:0]   mul_a;
    logic [2*MOD_W-1:0] product;

    // Remainder unit: shift in one dividend bit, subtract the modulus if it fits
    assign trial      = {rem_reg, div_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, m_reg};
    assign red_rem    = (trial >= {1'b0, m_reg}) ? trial_diff[MOD_W-1:0] : trial[MOD_W-1:0];

    // Shared multiplier
    assign mul_a   = (op_reg == OP_ACC) ? acc_reg : b_reg;
    assign product = mul_a * b_reg;

    assign operand.ready     = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.data.power_result = out_data_reg;

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once the sink takes it
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (operand.valid)
                begin
                    m_next     = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;
                    e_next     = operand.data.exponent & EXP_MASK;
                    acc_next   = MOD_W'(1);
                    div_next   = operand.data.base_value;
                    rem_next   = '0;
                    cnt_next   = '0;
                    op_next    = OP_BASE;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                rem_next = red_rem;
                div_next = {div_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    unique case (op_reg)
                        OP_ACC:
                        begin
                            acc_next = red_rem;
                            e_next   = {e_reg[EXP_W-1:1], 1'b0};
                        end
                        OP_SQR:
                        begin
                            b_next = red_rem;
                            e_next = {1'b0, e_reg[EXP_W-1:1]};
                        end
                        default:
                        begin
                            b_next = red_rem;
                        end
                    endcase
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                priority if (e_reg == '0)
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = acc_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    op_next    = OP_ACC;
                    state_next = S_MUL;
                end
                else
                begin
                    op_next    = OP_SQR;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                div_next   = {1'b0, product};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_REDUCE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_BASE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        b_reg        <= b_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_CLK(a_rem_below_mod, (state_reg == S_REDUCE) |-> (rem_reg < m_reg),
        "partial remainder reached the modulus")
    `ASSERT_CLK(a_acc_reduced, (state_reg == S_STEP) |-> (acc_reg < m_reg || acc_reg == 1),
        "running result not reduced")
    `ASSERT_NEXT(a_busy_after_take, operand.valid && operand.ready, !operand.ready,
        "operand taken while an item is in flight")
    `ASSERT_NEXT(a_result_from_step, !out_valid_reg && !(state_reg == S_STEP), !out_valid_reg,
        "result appeared without a finished item")

endmodule
